// ===== rtl/sbtdd_pkg.sv =====
// shared constants and types for the signed binary to decimal digit converter
package sbtdd_pkg;

  localparam int ValueWidth = 64;
  localparam int MaxDigits  = 19;
  localparam int DigitWidth = 4;
  localparam int BitCntW    = $clog2(ValueWidth);
  localparam int PtrW       = $clog2(MaxDigits);

  typedef logic [DigitWidth-1:0] digit_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_e;

endpackage

// ===== rtl/signed_binary_to_decimal_digits_top.sv =====
// Signed 64-bit integer to decimal digits, one digit per strobe. An item is
// taken when start is high and busy is low. The magnitude is converted by a
// bit-serial double-dabble shifter, one input bit per cycle. Then a pointer
// walks down past leading zero digits one per cycle and stops at the top
// nonzero digit, keeping at least one digit. Then the digits leave one per
// cycle on digit_o with digit_valid_o high, for exactly one cycle each;
// last_digit_o marks the final digit of the item, and busy drops the cycle
// after it. The receiver cannot stall the output. digit_order selects least
// significant digit first (0, reset value) or most significant digit first
// (1); write it only while busy is low.
module signed_binary_to_decimal_digits_top import sbtdd_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [ValueWidth-1:0] value_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         digit_order_i,
  output logic                         digit_valid_o,
  output logic [DigitWidth-1:0]        digit_o,
  output logic                         last_digit_o
);

  state_e                state_q, state_d;
  logic                  order_q;
  logic [ValueWidth-1:0] mag_q, mag_d;
  digit_t                bcd_q [MaxDigits];
  digit_t                bcd_d [MaxDigits];
  digit_t                adj   [MaxDigits];
  logic [BitCntW-1:0]    bit_cnt_q, bit_cnt_d;
  logic [PtrW-1:0]       ptr_q, ptr_d;
  logic [ValueWidth-1:0] val_u;
  logic [ValueWidth-1:0] val_neg;

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != ST_IDLE);

  assign val_u   = value_i;
  assign val_neg = ~val_u + ValueWidth'(1);

  // add-3 correction per digit before each shift
  always_comb begin
    for (int i = 0; i < MaxDigits; i++) begin
      adj[i] = (bcd_q[i] >= digit_t'(5)) ? bcd_q[i] + digit_t'(3) : bcd_q[i];
    end
  end

  always_comb begin
    state_d       = state_q;
    mag_d         = mag_q;
    bcd_d         = bcd_q;
    bit_cnt_d     = bit_cnt_q;
    ptr_d         = ptr_q;
    digit_valid_o = 1'b0;
    digit_o       = order_q ? bcd_q[ptr_q] : bcd_q[0];
    last_digit_o  = (ptr_q == '0);
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          mag_d     = val_u[ValueWidth-1] ? val_neg : val_u;
          bit_cnt_d = '0;
          for (int i = 0; i < MaxDigits; i++) begin
            bcd_d[i] = '0;
          end
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_d[0] = {adj[0][DigitWidth-2:0], mag_q[ValueWidth-1]};
        for (int i = 1; i < MaxDigits; i++) begin
          bcd_d[i] = {adj[i][DigitWidth-2:0], adj[i-1][DigitWidth-1]};
        end
        mag_d     = {mag_q[ValueWidth-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q + BitCntW'(1);
        if (bit_cnt_q == BitCntW'(ValueWidth - 1)) begin
          ptr_d   = PtrW'(MaxDigits - 1);
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // walk down past leading zero digits, keep at least one
        if (bcd_q[ptr_q] == '0 && ptr_q != '0) begin
          ptr_d = ptr_q - PtrW'(1);
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        digit_valid_o = 1'b1;
        if (!order_q) begin
          for (int i = 0; i < MaxDigits - 1; i++) begin
            bcd_d[i] = bcd_q[i+1];
          end
          bcd_d[MaxDigits-1] = '0;
        end
        if (ptr_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          ptr_d = ptr_q - PtrW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      order_q   <= 1'b0;
      bit_cnt_q <= '0;
      ptr_q     <= '0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
      ptr_q     <= ptr_d;
      if (cfg_valid_i && cfg_ready_o) begin
        order_q <= digit_order_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
  end

endmodule
